FILE: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the pixel format access unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // stored pixel layouts
  typedef enum logic [1:0] {
    FMT_MONO  = 2'd0,
    FMT_ALPHA = 2'd1,
    FMT_RGB   = 2'd2,
    FMT_RGBA  = 2'd3
  } pix_fmt_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FORMAT = 2'd2
  } reg_idx_t;

  // operations of the shared address unit
  typedef enum logic [2:0] {
    AOP_HOLD    = 3'd0,
    AOP_MAC_EXT = 3'd1,
    AOP_MAC_ACC = 3'd2,
    AOP_REDUCE  = 3'd3,
    AOP_INC     = 3'd4
  } addr_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_MAC_ROW = 3'd1,
    ST_MAC_PIX = 3'd2,
    ST_REDUCE  = 3'd3,
    ST_ACCESS  = 3'd4,
    ST_MONO_WR = 3'd5,
    ST_FLUSH   = 3'd6,
    ST_FIN     = 3'd7
  } seq_state_t;

  // status of the address unit toward the sequencer
  typedef struct packed {
    logic red_last;
    logic red_none;
  } addr_stat_t;

  localparam logic [7:0] WIDTH_RST  = 8'd128;
  localparam logic [7:0] HEIGHT_RST = 8'd128;
  localparam logic [1:0] CH_RED     = 2'd0;
  localparam logic [1:0] CH_ALPHA   = 2'd3;
  localparam logic [7:0] FULL_ON    = 8'd255;
  localparam int         MONO_SHIFT = 3;

endpackage

FILE: rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/pfa_cfg.sv
// ----------------------------------------------------------------------------
// pfa_cfg
// APB register block holding image width, image height and pixel format.
// ----------------------------------------------------------------------------
module pfa_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        image_width,
  output logic [7:0]        image_height,
  output pfa_pkg::pix_fmt_t pixel_format
);
  import pfa_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      pixel_format <= FMT_RGBA;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  image_width  <= pwdata[7:0];
        REG_HEIGHT: image_height <= pwdata[7:0];
        REG_FORMAT: pixel_format <= pix_fmt_t'(pwdata[1:0]);
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = {24'd0, image_width};
      REG_HEIGHT: prdata = {24'd0, image_height};
      REG_FORMAT: prdata = {30'd0, pixel_format};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/pfa_addr.sv
// ----------------------------------------------------------------------------
// pfa_addr
// Shared address unit: multiply-add, restoring modulo reduction by the store
// size, and wrapping increment, all on one accumulator.
// ----------------------------------------------------------------------------
module pfa_addr #(
  parameter int MAX_DIM     = 128,
  parameter int STORE_BYTES = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pfa_pkg::addr_op_t              op,
  input  logic [$clog2(MAX_DIM)-1:0]     opa,
  input  logic [7:0]                     opb,
  input  logic [$clog2(MAX_DIM)-1:0]     opc,
  output logic [$clog2(STORE_BYTES)-1:0] addr,
  output pfa_pkg::addr_stat_t            stat
);
  import pfa_pkg::*;

  localparam int ADDR_W    = $clog2(STORE_BYTES);
  localparam int LIN_W     = $clog2(MAX_DIM * MAX_DIM * 4);
  localparam int ACC_W     = (LIN_W > ADDR_W) ? LIN_W : ADDR_W;
  localparam int RED_STEPS = (LIN_W >= ADDR_W) ? LIN_W - ADDR_W + 1 : 0;
  localparam int RED_SHIFT = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
  localparam int RC_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam longint unsigned DSH_L = longint'(STORE_BYTES) << RED_SHIFT;
  localparam logic [ACC_W-1:0] DSH_INIT = ACC_W'(DSH_L);
  localparam logic [ACC_W:0]   STORE_V  = (ACC_W+1)'(STORE_BYTES);
  localparam logic [RC_W-1:0]  RED_INIT = RC_W'(RED_SHIFT);

  logic [ACC_W-1:0] acc, acc_next;
  logic [ACC_W-1:0] dsh, dsh_next;
  logic [RC_W-1:0]  red_cnt, red_cnt_next;
  logic [ACC_W-1:0] mul_a;
  logic [ACC_W+7:0] mac;
  logic [ACC_W:0]   inc;
  logic [ACC_W:0]   diff;

  // one multiplier, one subtractor and one incrementer shared by all steps
  always_comb begin
    mul_a = (op == AOP_MAC_ACC) ? acc : ACC_W'(opa);
    mac   = (ACC_W+8)'(mul_a) * (ACC_W+8)'(opb) + (ACC_W+8)'(opc);
    inc   = {1'b0, acc} + (ACC_W+1)'(1);
    diff  = {1'b0, acc} - {1'b0, dsh};

    acc_next     = acc;
    dsh_next     = dsh;
    red_cnt_next = red_cnt;
    case (op)
      AOP_MAC_EXT, AOP_MAC_ACC: begin
        acc_next     = mac[ACC_W-1:0];
        dsh_next     = DSH_INIT;
        red_cnt_next = RED_INIT;
      end
      AOP_REDUCE: begin
        // subtract the store size shifted down one place per step
        if (!diff[ACC_W]) begin
          acc_next = diff[ACC_W-1:0];
        end
        dsh_next     = dsh >> 1;
        red_cnt_next = red_cnt - RC_W'(1);
      end
      AOP_INC: begin
        acc_next = (inc == STORE_V) ? '0 : inc[ACC_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_cnt <= '0;
    end else begin
      red_cnt <= red_cnt_next;
    end
    acc <= acc_next;
    dsh <= dsh_next;
  end

  assign addr          = acc[ADDR_W-1:0];
  assign stat.red_last = (red_cnt == '0);
  assign stat.red_none = (RED_STEPS == 0);

endmodule

FILE: rtl/pixel_format_access_unit_top.sv
// ----------------------------------------------------------------------------
// pixel_format_access_unit_top
// Packed pixel store with configurable width, height and format, accessed
// one pixel per item through a byte-wide single-port RAM.
// ----------------------------------------------------------------------------
// One item at a time. An item whose coordinates miss the image goes straight
// to the finish state. A hit passes through the row multiply, the pixel-size
// multiply, R modulo reduction steps of the shared address unit and B store
// accesses, then a flush step for a read or a bit write for a monochrome
// write, where B is the bytes per pixel (1 monochrome or alpha, 3 RGB, 4
// RGBA) and R is $clog2(4*MAX_DIM^2) - $clog2(STORE_BYTES) + 1 or zero
// (one at the default sizes). The single byte-wide port of the store moves
// one byte per cycle. The store is not cleared at reset; a location must be
// written before it is read. The next item is taken while a result waits at
// the output.
module pixel_format_access_unit_top #(
  parameter int MAX_DIM     = 128,
  parameter int STORE_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [7:0]         red_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         blue_in,
  input  logic [7:0]         alpha_in,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [7:0]         red_out,
  output logic [7:0]         green_out,
  output logic [7:0]         blue_out,
  output logic [7:0]         alpha_out
);
  import pfa_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam logic [10:0] MAX_DIM_V = 11'(MAX_DIM);

  logic [7:0]  image_width, image_height;
  pix_fmt_t    pixel_format;
  logic [7:0]  w_eff, h_eff;
  logic [8:0]  row_bytes;
  logic        in_acc, hit_now;

  seq_state_t  state, state_next;
  logic [1:0]  cnt, cnt_next;
  logic [1:0]  ch;
  logic [2:0]  nbytes;
  logic        cap_vld, cap_vld_next;
  logic [1:0]  cap_ch, cap_ch_next;
  logic        out_load;

  logic             func_q, hit_q;
  logic [DIM_W-1:0] x_q, y_q;
  logic [7:0]       bit_q;
  logic [7:0]       col [4];

  addr_op_t         op;
  logic [DIM_W-1:0] opc;
  logic [7:0]       opb;
  addr_stat_t       stat;
  logic [ADDR_W-1:0] ram_addr;
  logic             ram_we;
  logic [7:0]       ram_wdata, ram_rdata;

  pfa_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_format (pixel_format)
  );

  pfa_addr #(
    .MAX_DIM     (MAX_DIM),
    .STORE_BYTES (STORE_BYTES)
  ) u_addr (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .opa  (y_q),
    .opb  (opb),
    .opc  (opc),
    .addr (ram_addr),
    .stat (stat)
  );

  pfa_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // clamp dimensions and test the coordinates
  always_comb begin
    w_eff = ({3'd0, image_width} > MAX_DIM_V) ? 8'(MAX_DIM_V) : image_width;
    h_eff = ({3'd0, image_height} > MAX_DIM_V) ? 8'(MAX_DIM_V) : image_height;
    row_bytes = ({1'b0, w_eff} + 9'd7) >> MONO_SHIFT;
    hit_now = !pos_x[15] && (pos_x[14:0] < {7'd0, w_eff}) &&
              !pos_y[15] && (pos_y[14:0] < {7'd0, h_eff});
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // bytes per pixel and the channel a byte belongs to
  always_comb begin
    case (pixel_format)
      FMT_MONO:  nbytes = 3'd1;
      FMT_ALPHA: nbytes = 3'd1;
      FMT_RGB:   nbytes = 3'd3;
      default:   nbytes = 3'd4;
    endcase
    ch = (pixel_format == FMT_ALPHA) ? CH_ALPHA : cnt;
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      cap_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      cap_vld <= cap_vld_next;
    end
    cap_ch <= cap_ch_next;
  end

  // sequencer next state and controls
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cap_vld_next = 1'b0;
    cap_ch_next  = cap_ch;
    op           = AOP_HOLD;
    opb          = 8'd0;
    opc          = '0;
    ram_we       = 1'b0;
    ram_wdata    = col[ch];
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_acc) begin
          state_next = hit_now ? ST_MAC_ROW : ST_FIN;
        end
      end
      ST_MAC_ROW: begin
        // row start plus column offset
        op = AOP_MAC_EXT;
        if (pixel_format == FMT_MONO) begin
          opb = row_bytes[7:0];
          opc = x_q >> MONO_SHIFT;
        end else begin
          opb = w_eff;
          opc = x_q;
        end
        state_next = ST_MAC_PIX;
      end
      ST_MAC_PIX: begin
        // scale to bytes
        op         = AOP_MAC_ACC;
        opb        = {5'd0, nbytes};
        state_next = stat.red_none ? ST_ACCESS : ST_REDUCE;
      end
      ST_REDUCE: begin
        op = AOP_REDUCE;
        if (stat.red_last) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        // one byte per cycle
        ram_we       = func_q && (pixel_format != FMT_MONO);
        op           = (pixel_format == FMT_MONO) ? AOP_HOLD : AOP_INC;
        cap_vld_next = !func_q;
        cap_ch_next  = ch;
        cnt_next     = cnt + 2'd1;
        if ({1'b0, cnt} == nbytes - 3'd1) begin
          if (pixel_format == FMT_MONO && func_q) begin
            state_next = ST_MONO_WR;
          end else begin
            state_next = func_q ? ST_FIN : ST_FLUSH;
          end
        end
      end
      ST_MONO_WR: begin
        // modify the one bit of the byte just read
        ram_we     = 1'b1;
        ram_wdata  = (col[CH_ALPHA] != 8'd0) ? (ram_rdata | bit_q) : (ram_rdata & ~bit_q);
        state_next = ST_FIN;
      end
      ST_FLUSH: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // item registers and read capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_q           <= func;
      hit_q            <= hit_now;
      x_q              <= pos_x[DIM_W-1:0];
      y_q              <= pos_y[DIM_W-1:0];
      bit_q            <= 8'd1 << pos_x[2:0];
      col[CH_RED]      <= red_in;
      col[1]           <= green_in;
      col[2]           <= blue_in;
      col[CH_ALPHA]    <= alpha_in;
    end else if (cap_vld) begin
      if (pixel_format == FMT_MONO) begin
        col[CH_ALPHA] <= ((ram_rdata & bit_q) != 8'd0) ? FULL_ON : 8'd0;
      end else begin
        col[cap_ch] <= ram_rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      hit       <= hit_q;
      red_out   <= (hit_q && !func_q) ? col[CH_RED]   : 8'd0;
      green_out <= (hit_q && !func_q) ? col[1]        : 8'd0;
      blue_out  <= (hit_q && !func_q) ? col[2]        : 8'd0;
      alpha_out <= (hit_q && !func_q) ? col[CH_ALPHA] : 8'd0;
    end
  end

  // a miss carries no color
  a_miss_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |->
      (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && alpha_out == 8'd0))
    else $error("miss result with nonzero color");

  // the block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("not busy after accept");

  // a read item never writes the store
  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && !func_q) |-> !ram_we)
    else $error("store written during a read");

  // read data is captured only right after a store access
  a_capture_window: assert property (@(posedge clk) disable iff (rst)
    cap_vld |-> (state == ST_ACCESS || state == ST_FLUSH))
    else $error("capture outside access window");

  // a result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives read and write items into the packed pixel store under several image
// sizes and formats, predicts each result from a private copy of the pixel
// bytes and compares every result field by field, in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import pfa_pkg::*;

  localparam int MAX_DIM      = 128;
  localparam int STORE_BYTES  = 65536;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic PIX_READ   = 1'b0;
  localparam logic PIX_WRITE  = 1'b1;

  typedef struct {
    logic               func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } pixel_req_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_resp_t;

  typedef struct {
    int x;
    int y;
  } coord_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = 1'b0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [7:0]         red_in = '0;
  logic [7:0]         green_in = '0;
  logic [7:0]         blue_in = '0;
  logic [7:0]         alpha_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic [7:0]         alpha_out;

  // shadow of the pixel store and of which bits hold a written value
  bit [7:0]    frame_bytes [STORE_BYTES];
  bit [7:0]    known_bits [STORE_BYTES];
  logic [7:0]  cfg_width = WIDTH_RST;
  logic [7:0]  cfg_height = HEIGHT_RST;
  pix_fmt_t    cfg_format = FMT_RGBA;
  pixel_resp_t pending_results [$];
  coord_t      written_spots [$];
  int          send_gap_pct = 37;
  int          stall_pct = 69;
  int          error_count = 0;
  int          cycle_count = 0;

  pixel_format_access_unit_top #(
    .MAX_DIM    (MAX_DIM),
    .STORE_BYTES(STORE_BYTES)
  ) dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int dim_limit(logic [7:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic bit in_image(int x, int y);
    return x >= 0 && y >= 0 && x < dim_limit(cfg_width) && y < dim_limit(cfg_height);
  endfunction

  function automatic int bytes_per_pixel();
    case (cfg_format)
      FMT_RGB:  return 3;
      FMT_RGBA: return 4;
      default:  return 1;
    endcase
  endfunction

  // byte k of the pixel at (x, y); mono rows are padded to whole bytes
  function automatic int byte_addr(int x, int y, int k);
    int w;
    w = dim_limit(cfg_width);
    case (cfg_format)
      FMT_MONO:  return (((w + 7) / 8) * y + x / 8) % STORE_BYTES;
      FMT_ALPHA: return (y * w + x) % STORE_BYTES;
      default:   return ((y * w + x) * bytes_per_pixel() + k) % STORE_BYTES;
    endcase
  endfunction

  function automatic logic [7:0] mono_bit(int x);
    return 8'(1 << (x % 8));
  endfunction

  // true when the item reads no bit that was never written
  function automatic bit op_is_safe(pixel_req_t op);
    int x;
    int y;
    int a;
    x = op.pos_x;
    y = op.pos_y;
    if (!in_image(x, y)) return 1'b1;
    if (cfg_format == FMT_MONO) begin
      a = byte_addr(x, y, 0);
      if (op.func == PIX_WRITE) return known_bits[a] == 8'hFF;
      return (known_bits[a] & mono_bit(x)) != 0;
    end
    if (op.func == PIX_WRITE) return 1'b1;
    for (int k = 0; k < bytes_per_pixel(); k++) begin
      if (known_bits[byte_addr(x, y, k)] != 8'hFF) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected result of one item; updates the shadow store
  function automatic pixel_resp_t apply_pixel_op(pixel_req_t op);
    pixel_resp_t res;
    logic [7:0]  chan [4];
    coord_t      spot;
    int          x;
    int          y;
    int          a;
    int          c;
    res = '0;
    x = op.pos_x;
    y = op.pos_y;
    if (!in_image(x, y)) return res;
    res.hit = 1'b1;
    chan = '{op.red, op.green, op.blue, op.alpha};
    if (cfg_format == FMT_MONO) begin
      a = byte_addr(x, y, 0);
      if (op.func == PIX_WRITE) begin
        if (op.alpha != 0) frame_bytes[a] |= mono_bit(x);
        else frame_bytes[a] &= ~mono_bit(x);
        known_bits[a] |= mono_bit(x);
      end else begin
        chan[CH_ALPHA] = ((frame_bytes[a] & mono_bit(x)) != 0) ? FULL_ON : 8'd0;
      end
    end else begin
      for (int k = 0; k < bytes_per_pixel(); k++) begin
        a = byte_addr(x, y, k);
        c = (cfg_format == FMT_ALPHA) ? int'(CH_ALPHA) : k;
        if (op.func == PIX_WRITE) begin
          frame_bytes[a] = chan[c];
          known_bits[a] = 8'hFF;
        end else begin
          chan[c] = frame_bytes[a];
        end
      end
    end
    if (op.func == PIX_WRITE) begin
      spot.x = x;
      spot.y = y;
      written_spots.push_back(spot);
    end else begin
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      res.alpha = chan[3];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic pixel_req_t pixel_op(logic f, int x, int y, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pixel_req_t op;
    op.func  = f;
    op.pos_x = 16'(x);
    op.pos_y = 16'(y);
    op.red   = r;
    op.green = g;
    op.blue  = b;
    op.alpha = a;
    return op;
  endfunction

  function automatic pixel_req_t random_pixel_op();
    pixel_req_t op;
    coord_t     spot;
    int         w;
    int         h;
    int         x;
    int         y;
    int         tries;
    w = dim_limit(cfg_width);
    h = dim_limit(cfg_height);
    op.func  = ($urandom_range(1) == 1) ? PIX_WRITE : PIX_READ;
    op.red   = 8'($urandom);
    op.green = 8'($urandom);
    op.blue  = 8'($urandom);
    op.alpha = 8'($urandom);
    // clear mono bits often enough
    if (cfg_format == FMT_MONO && op.func == PIX_WRITE && $urandom_range(2) == 0)
      op.alpha = 8'd0;
    x = $urandom_range(w > 0 ? w - 1 : 0);
    y = $urandom_range(h > 0 ? h - 1 : 0);
    if (w == 0 || h == 0 || $urandom_range(99) < 18) begin
      // off-image coordinates
      case ($urandom_range(4))
        0: x = -int'($urandom_range(32768, 1));
        1: x = $urandom_range(32767, w);
        2: y = -int'($urandom_range(32768, 1));
        3: y = $urandom_range(32767, h);
        default: begin
          x = int'($signed(16'($urandom)));
          y = int'($signed(16'($urandom)));
        end
      endcase
      op.pos_x = 16'(x);
      op.pos_y = 16'(y);
    end else begin
      op.pos_x = 16'(x);
      op.pos_y = 16'(y);
      // reads look for a pixel that holds written bytes
      for (tries = 0; tries < 4 && !op_is_safe(op); tries++) begin
        op.pos_x = 16'($urandom_range(w - 1));
        op.pos_y = 16'($urandom_range(h - 1));
      end
      if (!op_is_safe(op) && written_spots.size() > 0) begin
        spot = written_spots[$urandom_range(written_spots.size() - 1)];
        op.pos_x = 16'(spot.x);
        op.pos_y = 16'(spot.y);
      end
    end
    if (!op_is_safe(op)) op.func = PIX_WRITE;
    if (!op_is_safe(op)) op.pos_y = -16'sd1;
    return op;
  endfunction

  // sends one item and records its expected result once accepted
  task automatic issue_pixel_op(pixel_req_t op);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op.func;
    pos_x    <= op.pos_x;
    pos_y    <= op.pos_y;
    red_in   <= op.red;
    green_in <= op.green;
    blue_in  <= op.blue;
    alpha_in <= op.alpha;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_pixel_op(op));
  endtask

  // holds off the sender until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // register write followed by a read back
  task automatic apb_write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  cfg_width = value[7:0];
      REG_HEIGHT: cfg_height = value[7:0];
      default:    cfg_format = pix_fmt_t'(value[1:0]);
    endcase
  endtask

  // reconfigures the image; mono images get every byte written first since
  // a mono write changes one bit of a stored byte
  task automatic set_image(logic [7:0] w, logic [7:0] h, pix_fmt_t fmt);
    int w8;
    wait_idle();
    if (fmt == FMT_MONO) begin
      w8 = (dim_limit(w) + 7) / 8;
      apb_write_reg(REG_WIDTH, 32'(w8));
      apb_write_reg(REG_HEIGHT, 32'(h));
      apb_write_reg(REG_FORMAT, 32'(FMT_ALPHA));
      for (int row = 0; row < dim_limit(h); row++) begin
        for (int col = 0; col < w8; col++)
          issue_pixel_op(pixel_op(PIX_WRITE, col, row, 8'd0, 8'd0, 8'd0, 8'($urandom)));
      end
      wait_idle();
    end
    apb_write_reg(REG_WIDTH, 32'(w));
    apb_write_reg(REG_HEIGHT, 32'(h));
    apb_write_reg(REG_FORMAT, 32'(fmt));
    written_spots.delete();
  endtask

  // ---------------------------------------------------------------- tests

  // corners of the full-size rgba image and far-off coordinates
  task automatic test_rgba_corners();
    issue_pixel_op(pixel_op(PIX_WRITE, 0, 0, 8'h00, 8'hFF, 8'h55, 8'hAA));
    issue_pixel_op(pixel_op(PIX_WRITE, 127, 127, 8'hFF, 8'h00, 8'hAA, 8'h55));
    issue_pixel_op(pixel_op(PIX_WRITE, 127, 0, 8'h12, 8'h34, 8'h56, 8'h78));
    issue_pixel_op(pixel_op(PIX_READ, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue_pixel_op(pixel_op(PIX_READ, 127, 127, 8'h00, 8'h00, 8'h00, 8'h00));
    issue_pixel_op(pixel_op(PIX_READ, 127, 0, 8'h81, 8'h42, 8'h24, 8'h18));
    issue_pixel_op(pixel_op(PIX_READ, -1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue_pixel_op(pixel_op(PIX_WRITE, 0, -1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue_pixel_op(pixel_op(PIX_WRITE, 128, 5, 8'h01, 8'h02, 8'h03, 8'h04));
    issue_pixel_op(pixel_op(PIX_READ, -32768, 32767, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue_pixel_op(pixel_op(PIX_WRITE, 32767, -32768, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // single bits set and cleared, neighbors kept, row padding
  task automatic test_mono_bits();
    set_image(8'd10, 8'd3, FMT_MONO);
    issue_pixel_op(pixel_op(PIX_WRITE, 0, 0, 8'h00, 8'h00, 8'h00, 8'hFF));
    issue_pixel_op(pixel_op(PIX_WRITE, 7, 0, 8'h00, 8'h00, 8'h00, 8'h01));
    issue_pixel_op(pixel_op(PIX_WRITE, 8, 0, 8'h00, 8'h00, 8'h00, 8'hC8));
    issue_pixel_op(pixel_op(PIX_WRITE, 9, 2, 8'h00, 8'h00, 8'h00, 8'hFF));
    issue_pixel_op(pixel_op(PIX_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    issue_pixel_op(pixel_op(PIX_READ, 0, 0, 8'h11, 8'h22, 8'h33, 8'h44));
    issue_pixel_op(pixel_op(PIX_READ, 7, 0, 8'h11, 8'h22, 8'h33, 8'h44));
    issue_pixel_op(pixel_op(PIX_READ, 8, 0, 8'h11, 8'h22, 8'h33, 8'h44));
    issue_pixel_op(pixel_op(PIX_READ, 9, 2, 8'h11, 8'h22, 8'h33, 8'h44));
    issue_pixel_op(pixel_op(PIX_READ, 10, 0, 8'h11, 8'h22, 8'h33, 8'h44));
  endtask

  // zero width misses everything, oversized dimensions act as the maximum
  task automatic test_size_limits();
    set_image(8'd0, 8'd5, FMT_ALPHA);
    issue_pixel_op(pixel_op(PIX_WRITE, 0, 0, 8'h00, 8'h00, 8'h00, 8'h77));
    issue_pixel_op(pixel_op(PIX_READ, 0, 0, 8'h01, 8'h02, 8'h03, 8'h04));
    set_image(8'd255, 8'd200, FMT_ALPHA);
    issue_pixel_op(pixel_op(PIX_WRITE, 127, 127, 8'h00, 8'h00, 8'h00, 8'h5A));
    issue_pixel_op(pixel_op(PIX_READ, 127, 127, 8'hA1, 8'hB2, 8'hC3, 8'hD4));
    issue_pixel_op(pixel_op(PIX_WRITE, 0, 128, 8'h00, 8'h00, 8'h00, 8'h33));
    issue_pixel_op(pixel_op(PIX_READ, 128, 3, 8'hA1, 8'hB2, 8'hC3, 8'hD4));
  endtask

  // random reads and writes across a series of image settings
  task automatic test_random_traffic();
    int       set_w [9]     = '{128, 1, 37, 128, 1, 20, 255, 13, 9};
    int       set_h [9]     = '{128, 1, 5, 4, 128, 9, 2, 6, 200};
    pix_fmt_t set_fmt [9]   = '{FMT_RGBA, FMT_RGB, FMT_RGB, FMT_MONO, FMT_MONO,
                                FMT_ALPHA, FMT_RGBA, FMT_MONO, FMT_ALPHA};
    int       set_items [9] = '{160, 30, 120, 120, 80, 120, 95, 95, 93};
    int       total;
    int       done;
    total = 0;
    done = 0;
    foreach (set_items[i]) total += set_items[i];
    foreach (set_w[s]) begin
      set_image(8'(set_w[s]), 8'(set_h[s]), set_fmt[s]);
      for (int n = 0; n < set_items[s]; n++) begin
        if (done < total / 3) begin
          send_gap_pct = 37;
          stall_pct = 69;
        end else if (done < 2 * total / 3) begin
          send_gap_pct = 69;
          stall_pct = 37;
        end else begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        // sender holds until everything outstanding has returned
        if (done == total / 2) wait_idle();
        issue_pixel_op(random_pixel_op());
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  // compares each accepted result with the oldest expectation
  always @(posedge clk) begin
    pixel_resp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none actual hit=%0h rgba=%h%h%h%h",
                 $time, hit, red_out, green_out, blue_out, alpha_out);
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("red_out", 32'(want.red), 32'(red_out));
        check_field("green_out", 32'(want.green), 32'(green_out));
        check_field("blue_out", 32'(want.blue), 32'(blue_out));
        check_field("alpha_out", 32'(want.alpha), 32'(alpha_out));
      end
    end
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[pixel_format_access_unit_top] ERROR");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rgba_corners();
    test_mono_bits();
    test_size_limits();
    test_random_traffic();
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[pixel_format_access_unit_top] OK");
    end else begin
      $display("[pixel_format_access_unit_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: pixel_format_access_unit_top.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_cfg.sv
rtl/pfa_addr.sv
rtl/pixel_format_access_unit_top.sv
verif/testbench.sv
